@@ hdl/bli_pkg.sv @@
// ----------------------------------------------------------------------------
// bli_pkg: shared definitions for the bilinear interpolation pipeline
// Default widths, stage counts of each section, port field positions and the
// flag bundle that rides along the datapath.
// ----------------------------------------------------------------------------
package bli_pkg;

  // Default sample width (signed fixed point, Q16.16 at 32 bits)
  localparam int DATA_WIDTH_DEF = 32;

  // Input beat carries ten fields, in this order from the lowest bits up
  localparam int N_IN_FIELDS   = 10;
  localparam int FLD_CORNER_A  = 0;
  localparam int FLD_CORNER_B  = 1;
  localparam int FLD_CORNER_C  = 2;
  localparam int FLD_CORNER_D  = 3;
  localparam int FLD_X_LOW     = 4;
  localparam int FLD_X_HIGH    = 5;
  localparam int FLD_Y_LOW     = 6;
  localparam int FLD_Y_HIGH    = 7;
  localparam int FLD_QUERY_X   = 8;
  localparam int FLD_QUERY_Y   = 9;

  // Output sideband bits
  localparam int TUSER_W       = 2;
  localparam int TU_ZERO_AREA  = 0;
  localparam int TU_CLIPPED    = 1;

  // Stage counts: multiply/accumulate front, divider setup, rounding back end
  localparam int MAC_STAGES    = 6;
  localparam int DIV_PRE       = 2;
  localparam int BACK_STAGES   = 2;

  // Status carried alongside the quotient datapath
  typedef struct packed {
    logic zero_area;  // degenerate cell
    logic neg;        // quotient sign
    logic ovf;        // quotient magnitude beyond the output range
  } bli_flags_t;

endpackage

@@ hdl/bli_mac.sv @@
// ----------------------------------------------------------------------------
// bli_mac: numerator and denominator front end
// Six stages: coordinate differences, difference products, split corner
// products, term assembly, and a two-level adder tree for the numerator.
// ----------------------------------------------------------------------------
module bli_mac import bli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int DFW = DATA_WIDTH + 1,        // coordinate difference
  localparam int PW  = 2 * DFW,               // product of two differences
  localparam int NW  = 3 * DATA_WIDTH + 4     // numerator
) (
  input  logic                         clk,
  input  logic [MAC_STAGES-1:0]        ld,
  input  logic signed [DATA_WIDTH-1:0] corner_a,
  input  logic signed [DATA_WIDTH-1:0] corner_b,
  input  logic signed [DATA_WIDTH-1:0] corner_c,
  input  logic signed [DATA_WIDTH-1:0] corner_d,
  input  logic signed [DATA_WIDTH-1:0] grid_x_low,
  input  logic signed [DATA_WIDTH-1:0] grid_x_high,
  input  logic signed [DATA_WIDTH-1:0] grid_y_low,
  input  logic signed [DATA_WIDTH-1:0] grid_y_high,
  input  logic signed [DATA_WIDTH-1:0] query_x,
  input  logic signed [DATA_WIDTH-1:0] query_y,
  output logic signed [NW-1:0]         num,
  output logic signed [PW-1:0]         den,
  output logic                         zero_area
);

  localparam int DW  = DATA_WIDTH;
  localparam int LOW = DFW;            // low slice of a product, unsigned
  localparam int PLW = DW + LOW + 1;   // corner x low slice
  localparam int PHW = DW + PW - LOW;  // corner x high slice

  // stage 0: differences
  logic signed [DFW-1:0] dx_r, dy_r, x2x_r, xx1_r, y2y_r, yy1_r;
  logic signed [DW-1:0]  c0_r [4];
  // stage 1: difference products
  logic signed [PW-1:0]  p1_r [4];
  logic signed [DW-1:0]  c1_r [4];
  // stage 2: partial products
  logic signed [PLW-1:0] pl2_r [4];
  logic signed [PHW-1:0] ph2_r [4];
  // stage 3: full terms
  logic signed [NW-1:0]  t3_r [4];
  // stage 4: pair sums
  logic signed [NW-1:0]  s4_r [2];
  // stage 5: numerator
  logic signed [NW-1:0]  num5_r;
  // denominator and degenerate flag shift lines
  logic signed [PW-1:0]  den_r [1:5];
  logic                  zero_r [0:5];

  // Stage 0: coordinate differences at one extra bit
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dx_r      <= DFW'(grid_x_high) - DFW'(grid_x_low);
      dy_r      <= DFW'(grid_y_high) - DFW'(grid_y_low);
      x2x_r     <= DFW'(grid_x_high) - DFW'(query_x);
      xx1_r     <= DFW'(query_x) - DFW'(grid_x_low);
      y2y_r     <= DFW'(grid_y_high) - DFW'(query_y);
      yy1_r     <= DFW'(query_y) - DFW'(grid_y_low);
      c0_r[0]   <= corner_a;
      c0_r[1]   <= corner_c;
      c0_r[2]   <= corner_b;
      c0_r[3]   <= corner_d;
      zero_r[0] <= (grid_x_high == grid_x_low) || (grid_y_high == grid_y_low);
    end
  end

  // Stage 1: weight products and cell area, one DFW x DFW multiplier each
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p1_r[0]   <= PW'(x2x_r) * PW'(y2y_r);
      p1_r[1]   <= PW'(xx1_r) * PW'(y2y_r);
      p1_r[2]   <= PW'(x2x_r) * PW'(yy1_r);
      p1_r[3]   <= PW'(xx1_r) * PW'(yy1_r);
      den_r[1]  <= PW'(dx_r) * PW'(dy_r);
      c1_r      <= c0_r;
      zero_r[1] <= zero_r[0];
    end
  end

  // Stage 2: corner times weight, split into low (unsigned) and high (signed) halves
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 4; i++) begin
        pl2_r[i] <= PLW'(c1_r[i]) * PLW'($signed({1'b0, p1_r[i][LOW-1:0]}));
        ph2_r[i] <= PHW'(c1_r[i]) * PHW'($signed(p1_r[i][PW-1:LOW]));
      end
      den_r[2]  <= den_r[1];
      zero_r[2] <= zero_r[1];
    end
  end

  // Stage 3: recombine halves
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 4; i++) begin
        t3_r[i] <= (NW'(ph2_r[i]) <<< LOW) + NW'(pl2_r[i]);
      end
      den_r[3]  <= den_r[2];
      zero_r[3] <= zero_r[2];
    end
  end

  // Stage 4: first adder level
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_r[0]   <= t3_r[0] + t3_r[1];
      s4_r[1]   <= t3_r[2] + t3_r[3];
      den_r[4]  <= den_r[3];
      zero_r[4] <= zero_r[3];
    end
  end

  // Stage 5: numerator
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      num5_r    <= s4_r[0] + s4_r[1];
      den_r[5]  <= den_r[4];
      zero_r[5] <= zero_r[4];
    end
  end

  assign num       = num5_r;
  assign den       = den_r[5];
  assign zero_area = zero_r[5];

endmodule

@@ hdl/bli_div_step.sv @@
// ----------------------------------------------------------------------------
// bli_div_step: one restoring division step
// Compares the partial remainder with the divisor shifted to this step's
// quotient bit, subtracts on success and shifts the bit into the quotient.
// ----------------------------------------------------------------------------
module bli_div_step import bli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int SHIFT      = 0,
  localparam int PW = 2 * (DATA_WIDTH + 1),
  localparam int NW = 3 * DATA_WIDTH + 4
) (
  input  logic                  clk,
  input  logic                  ld,
  input  logic [NW-1:0]         r_in,
  input  logic [PW-1:0]         d_in,
  input  logic [DATA_WIDTH-1:0] q_in,
  input  bli_flags_t            f_in,
  output logic [NW-1:0]         r_out,
  output logic [PW-1:0]         d_out,
  output logic [DATA_WIDTH-1:0] q_out,
  output bli_flags_t            f_out
);

  logic [NW:0] diff;
  logic        ge;

  // trial subtract; the top bit is the borrow
  assign diff = {1'b0, r_in} - {1'b0, NW'(d_in) << SHIFT};
  assign ge   = ~diff[NW];

  always_ff @(posedge clk) begin
    if (ld) begin
      r_out <= ge ? diff[NW-1:0] : r_in;
      q_out <= {q_in[DATA_WIDTH-2:0], ge};
      d_out <= d_in;
      f_out <= f_in;
    end
  end

endmodule

@@ hdl/bli_divider.sv @@
// ----------------------------------------------------------------------------
// bli_divider: pipelined magnitude divider
// Takes signs and magnitudes, flags a quotient that needs more than
// DATA_WIDTH bits, then resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module bli_divider import bli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW  = 2 * (DATA_WIDTH + 1),
  localparam int NW  = 3 * DATA_WIDTH + 4,
  localparam int NST = DIV_PRE + DATA_WIDTH
) (
  input  logic                  clk,
  input  logic [NST-1:0]        ld,
  input  logic signed [NW-1:0]  num,
  input  logic signed [PW-1:0]  den,
  input  logic                  zero_area,
  output logic [DATA_WIDTH-1:0] quo,
  output logic [PW-1:0]         rem,
  output logic [PW-1:0]         dvs,
  output bli_flags_t            flags
);

  localparam int DW = DATA_WIDTH;

  logic [NW-1:0]   n0_r;
  logic [PW-1:0]   d0_r;
  bli_flags_t      f0_r;

  // step chain, entry 0 is the setup stage output
  logic [NW-1:0]   r_w [0:DW];
  logic [PW-1:0]   d_w [0:DW];
  logic [DW-1:0]   q_w [0:DW];
  bli_flags_t      f_w [0:DW];

  logic [NW-1:0]   r1_r;
  logic [PW-1:0]   d1_r;
  bli_flags_t      f1_r;

  // Stage 0: sign of quotient and operand magnitudes
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      n0_r           <= num[NW-1] ? NW'(-num) : NW'(num);
      d0_r           <= den[PW-1] ? PW'(-den) : PW'(den);
      f0_r.zero_area <= zero_area;
      f0_r.neg       <= num[NW-1] ^ den[PW-1];
      f0_r.ovf       <= 1'b0;
    end
  end

  // Stage 1: range check, quotient >= 2^DW saturates regardless of rounding
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      r1_r           <= n0_r;
      d1_r           <= d0_r;
      f1_r.zero_area <= f0_r.zero_area;
      f1_r.neg       <= f0_r.neg;
      f1_r.ovf       <= n0_r >= (NW'(d0_r) << DW);
    end
  end

  assign r_w[0] = r1_r;
  assign d_w[0] = d1_r;
  assign q_w[0] = '0;
  assign f_w[0] = f1_r;

  // One quotient bit per stage, MSB first
  for (genvar j = 0; j < DW; j++) begin : g_step
    bli_div_step #(
      .DATA_WIDTH (DATA_WIDTH),
      .SHIFT      (DW - 1 - j)
    ) u_step (
      .clk   (clk),
      .ld    (ld[DIV_PRE + j]),
      .r_in  (r_w[j]),
      .d_in  (d_w[j]),
      .q_in  (q_w[j]),
      .f_in  (f_w[j]),
      .r_out (r_w[j+1]),
      .d_out (d_w[j+1]),
      .q_out (q_w[j+1]),
      .f_out (f_w[j+1])
    );
  end

  // an in-range quotient leaves a final remainder below the divisor, so it fits the divisor width
  assign quo   = q_w[DW];
  assign rem   = r_w[DW][PW-1:0];
  assign dvs   = d_w[DW];
  assign flags = f_w[DW];

endmodule

@@ hdl/bli_round.sv @@
// ----------------------------------------------------------------------------
// bli_round: rounding, saturation and output register
// Rounds the magnitude half away from zero, clamps to the signed range,
// applies the sign and forces zero for a degenerate cell.
// ----------------------------------------------------------------------------
module bli_round import bli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW = 2 * (DATA_WIDTH + 1)
) (
  input  logic                         clk,
  input  logic [BACK_STAGES-1:0]       ld,
  input  logic [DATA_WIDTH-1:0]        quo,
  input  logic [PW-1:0]                rem,
  input  logic [PW-1:0]                dvs,
  input  bli_flags_t                   flags,
  output logic signed [DATA_WIDTH-1:0] interpolated,
  output logic                         zero_area,
  output logic                         clipped
);

  localparam int DW = DATA_WIDTH;
  localparam logic [DW:0]   LIM_POS = (DW+1)'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [DW:0]   LIM_NEG = (DW+1)'(64'd1 << (DW - 1));
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic [DW:0]       qr_r;
  bli_flags_t        f_r;
  logic [DW:0]       lim;
  logic              over;
  logic [DW-1:0]     mag;
  logic [DW-1:0]     res_nxt;
  logic              clip_nxt;
  logic [DW-1:0]     res_r;
  logic              zero_r;
  logic              clip_r;

  // Stage 0: round half away from zero on the magnitude
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      qr_r <= (DW+1)'(quo) + (DW+1)'({rem, 1'b0} >= {1'b0, dvs});
      f_r  <= flags;
    end
  end

  // Saturate and apply sign
  always_comb begin
    lim      = f_r.neg ? LIM_NEG : LIM_POS;
    over     = f_r.ovf || (qr_r > lim);
    mag      = qr_r[DW-1:0];
    res_nxt  = f_r.neg ? (DW'(0) - mag) : mag;
    clip_nxt = 1'b0;
    if (f_r.zero_area) begin
      res_nxt = '0;
    end else if (over) begin
      res_nxt  = f_r.neg ? SAT_MIN : SAT_MAX;
      clip_nxt = 1'b1;
    end
  end

  // Stage 1: output register
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      res_r  <= res_nxt;
      zero_r <= f_r.zero_area;
      clip_r <= clip_nxt;
    end
  end

  assign interpolated = $signed(res_r);
  assign zero_area    = zero_r;
  assign clipped      = clip_r;

endmodule

@@ hdl/bilinear_interpolation_2d_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_interpolation_2d_top: pipelined bilinear interpolation
// Weighted sum of four cell corners divided by the cell area, rounded and
// saturated to signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one beat per query with the four corner values, the two
//   grid coordinates on each axis and the query point, all signed fixed point.
//   Output stream: one beat per query with the interpolated value in tdata
//   and the flags zero_area and clipped in tuser. Results leave in order.
//   Throughput: one beat per cycle, sustained, when the receiver keeps ready
//   high. The pipeline depth is set by the restoring divider that resolves
//   one quotient bit per stage behind a six-stage multiply/add front end.
//   Backpressure: a stalled output holds its beat; stages behind it keep
//   moving into empty slots, and in_tready drops once the first stage is
//   occupied while the output is stalled. Nothing is dropped.
//   Reset: synchronous, active low; clears all valid bits, the pipeline
//   comes out empty and ready. The block keeps no other state.
// ----------------------------------------------------------------------------
module bilinear_interpolation_2d_top import bli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((N_IN_FIELDS * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input beat
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // corner_a, corner_b, corner_c, corner_d, grid_x_low, grid_x_high,
  // grid_y_low, grid_y_high, query_x, query_y (lowest bits first)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result beat
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // interpolated
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // zero_area, clipped (lowest bit first)
  output logic [TUSER_W-1:0]     out_tuser
);

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * (DW + 1);
  localparam int NW   = 3 * DW + 4;
  localparam int DIVS = DIV_PRE + DW;
  localparam int NSTG = MAC_STAGES + DIVS + BACK_STAGES;
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic [NSTG-1:0]        v_r, v_nxt, v_prev;
  logic [NSTG:0]          ld;

  logic signed [NW-1:0]   num;
  logic signed [PW-1:0]   den;
  logic                   mac_zero;
  logic [DW-1:0]          quo;
  logic [PW-1:0]          rem;
  logic [PW-1:0]          dvs;
  bli_flags_t             div_flags;
  logic signed [DW-1:0]   res;
  logic                   res_zero;
  logic                   res_clip;

  // Stage advance: a stage loads when it is empty or the output drains.
  // A full stage that cannot load hands its beat on when the next one loads.
  always_comb begin
    v_prev   = {v_r[NSTG-2:0], in_tvalid};
    ld[NSTG] = out_tready;
    for (int k = 0; k < NSTG; k++) begin
      ld[k]    = ~v_r[k] | out_tready;
      v_nxt[k] = ld[k] ? v_prev[k] : (v_r[k] & ~ld[k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = v_r[NSTG-1];

  // Front end: differences, products, numerator and area
  bli_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk         (clk),
    .ld          (ld[MAC_STAGES-1:0]),
    .corner_a    (in_tdata[FLD_CORNER_A*DW +: DW]),
    .corner_b    (in_tdata[FLD_CORNER_B*DW +: DW]),
    .corner_c    (in_tdata[FLD_CORNER_C*DW +: DW]),
    .corner_d    (in_tdata[FLD_CORNER_D*DW +: DW]),
    .grid_x_low  (in_tdata[FLD_X_LOW*DW +: DW]),
    .grid_x_high (in_tdata[FLD_X_HIGH*DW +: DW]),
    .grid_y_low  (in_tdata[FLD_Y_LOW*DW +: DW]),
    .grid_y_high (in_tdata[FLD_Y_HIGH*DW +: DW]),
    .query_x     (in_tdata[FLD_QUERY_X*DW +: DW]),
    .query_y     (in_tdata[FLD_QUERY_Y*DW +: DW]),
    .num         (num),
    .den         (den),
    .zero_area   (mac_zero)
  );

  // Divider: one quotient bit per stage
  bli_divider #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .ld        (ld[MAC_STAGES +: DIVS]),
    .num       (num),
    .den       (den),
    .zero_area (mac_zero),
    .quo       (quo),
    .rem       (rem),
    .dvs       (dvs),
    .flags     (div_flags)
  );

  // Rounding, saturation, output register
  bli_round #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_round (
    .clk          (clk),
    .ld           (ld[MAC_STAGES + DIVS +: BACK_STAGES]),
    .quo          (quo),
    .rem          (rem),
    .dvs          (dvs),
    .flags        (div_flags),
    .interpolated (res),
    .zero_area    (res_zero),
    .clipped      (res_clip)
  );

  assign out_tdata = OUT_TDATA_W'($unsigned(res));

  always_comb begin
    out_tuser               = '0;
    out_tuser[TU_ZERO_AREA] = res_zero;
    out_tuser[TU_CLIPPED]   = res_clip;
  end

`ifndef NO_ASSERTIONS
  // beats in flight change only by accepted inputs and delivered outputs
  ast_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(v_r) == $countones($past(v_r))
        + ($past(in_tvalid && in_tready) ? 1 : 0)
        - ($past(out_tvalid && out_tready) ? 1 : 0)))
    else $error("pipeline occupancy mismatch");

  // degenerate cell gives zero and never reports saturation
  ast_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_zero) |-> (!res_clip && res == '0))
    else $error("zero-area result not cleared");

  // a clipped result sits at one of the range limits
  ast_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_clip) |-> ($unsigned(res) == SAT_MAX || $unsigned(res) == SAT_MIN))
    else $error("clipped result not at a limit");
`endif

endmodule

@@ dv/tb_bilinear_interpolation_2d_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_interpolation_2d_top: self-checking bench for the interpolator
// Drives query beats with random gaps and back-pressure, predicts each result
// from the corner values with exact wide integer arithmetic and compares the
// value, zero_area and clipped flags of every result beat in order.
// ----------------------------------------------------------------------------
module tb_bilinear_interpolation_2d_top;
  import bli_pkg::*;

  localparam int DW       = DATA_WIDTH_DEF;
  localparam int FRAC     = 16;
  localparam int IN_W     = ((N_IN_FIELDS * DW + 7) / 8) * 8;
  localparam int OUT_W    = ((DW + 7) / 8) * 8;
  localparam int HOLD_LEN = 300;   // long receiver hold-off, cycles
  localparam int WD_LIMIT = 2000;  // cycles without any beat before giving up
  localparam int TAIL     = 60;    // pipeline latency plus margin

  localparam logic signed [DW-1:0] ONE  = 1 <<< FRAC;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct {
    logic signed [DW-1:0] fld [N_IN_FIELDS];
  } query_t;

  typedef struct packed {
    logic signed [DW-1:0] interpolated;
    logic                 zero_area;
    logic                 clipped;
  } interp_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: exact bilinear prediction and in-order comparison
  // --------------------------------------------------------------------------
  class interp_scoreboard;
    interp_result_t pending_results[$];
    int n_queries;
    int n_results;
    int n_errors;
    int n_zero_area;
    int n_clipped;

    // full-width weighted sum over area, rounded half away from zero, saturated
    function interp_result_t interpolate(query_t q);
      logic signed [127:0] ca, cb, cc, cd, xl, xh, yl, yh, qx, qy;
      logic signed [127:0] wx_hi, wx_lo, wy_hi, wy_lo, num, area;
      logic [127:0] mag_num, mag_area, quo, rem, lim;
      logic neg;
      interp_result_t r;
      r = '0;
      ca = q.fld[FLD_CORNER_A];
      cb = q.fld[FLD_CORNER_B];
      cc = q.fld[FLD_CORNER_C];
      cd = q.fld[FLD_CORNER_D];
      xl = q.fld[FLD_X_LOW];
      xh = q.fld[FLD_X_HIGH];
      yl = q.fld[FLD_Y_LOW];
      yh = q.fld[FLD_Y_HIGH];
      qx = q.fld[FLD_QUERY_X];
      qy = q.fld[FLD_QUERY_Y];
      if (xh == xl || yh == yl) begin
        r.zero_area = 1'b1;
        return r;
      end
      wx_hi = xh - qx;
      wx_lo = qx - xl;
      wy_hi = yh - qy;
      wy_lo = qy - yl;
      num  = ca * wx_hi * wy_hi + cc * wx_lo * wy_hi
           + cb * wx_hi * wy_lo + cd * wx_lo * wy_lo;
      area = (xh - xl) * (yh - yl);
      neg      = num[127] ^ area[127];
      mag_num  = num[127] ? -num : num;
      mag_area = area[127] ? -area : area;
      quo = mag_num / mag_area;
      rem = mag_num % mag_area;
      if ((rem << 1) >= mag_area) quo = quo + 1;
      // negative side reaches one step further than the positive side
      lim = neg ? (128'd1 << (DW - 1)) : ((128'd1 << (DW - 1)) - 1);
      if (quo > lim) begin
        quo = lim;
        r.clipped = 1'b1;
      end
      r.interpolated = neg ? -quo[DW-1:0] : quo[DW-1:0];
      return r;
    endfunction

    function void note_query(query_t q);
      interp_result_t e;
      e = interpolate(q);
      pending_results.push_back(e);
      n_queries++;
      if (e.zero_area) n_zero_area++;
      if (e.clipped) n_clipped++;
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic [TUSER_W-1:0] user);
      interp_result_t e;
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat data=%h zero_area=%b clipped=%b",
                 $time, data[DW-1:0], user[TU_ZERO_AREA], user[TU_CLIPPED]);
        return;
      end
      e = pending_results.pop_front();
      if (data[DW-1:0] !== e.interpolated || user[TU_ZERO_AREA] !== e.zero_area ||
          user[TU_CLIPPED] !== e.clipped) begin
        n_errors++;
        $display({"%0t: result mismatch: expected data=%h zero_area=%b clipped=%b,",
                  " got data=%h zero_area=%b clipped=%b"},
                 $time, e.interpolated, e.zero_area, e.clipped,
                 data[DW-1:0], user[TU_ZERO_AREA], user[TU_CLIPPED]);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared state
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;

  interp_scoreboard sb = new();
  query_t drv_query;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int in_stall_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bilinear_interpolation_2d_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // signed value in [-2^bits, 2^bits-1]
  function automatic logic signed [DW-1:0] rand_span(int bits);
    logic signed [DW-1:0] v;
    v = $urandom;
    return v >>> (31 - bits);
  endfunction

  function automatic logic signed [DW-1:0] rand_extreme();
    case ($urandom_range(0, 7))
      0: return MINV;
      1: return MAXV;
      2: return '0;
      3: return 1;
      4: return -1;
      5: return ONE;
      6: return -ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic query_t mk(input logic signed [DW-1:0] a, b, c, d,
                                input logic signed [DW-1:0] xl, xh, yl, yh, qx, qy);
    query_t q;
    q.fld[FLD_CORNER_A] = a;
    q.fld[FLD_CORNER_B] = b;
    q.fld[FLD_CORNER_C] = c;
    q.fld[FLD_CORNER_D] = d;
    q.fld[FLD_X_LOW]    = xl;
    q.fld[FLD_X_HIGH]   = xh;
    q.fld[FLD_Y_LOW]    = yl;
    q.fld[FLD_Y_HIGH]   = yh;
    q.fld[FLD_QUERY_X]  = qx;
    q.fld[FLD_QUERY_Y]  = qy;
    return q;
  endfunction

  // one grid axis: low edge, signed width and a query placed by a fraction
  function automatic void rand_axis(input bit outside, output logic signed [DW-1:0] lo,
                                    output logic signed [DW-1:0] hi,
                                    output logic signed [DW-1:0] pos);
    longint w;
    longint frac;
    int wexp;
    wexp = $urandom_range(0, 22);
    lo   = rand_span($urandom_range(8, 28));
    w    = 1 + longint'($urandom & ((32'd1 << wexp) - 1));
    if ($urandom_range(0, 4) == 0) w = -w;
    frac = outside ? longint'($urandom_range(0, 16384)) - 6144
                   : longint'($urandom_range(0, 4096));
    hi  = DW'(longint'(lo) + w);
    pos = DW'(longint'(lo) + (w * frac) / 4096);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int kind;
    bit outside;
    kind = $urandom_range(0, 99);
    for (int f = 0; f < N_IN_FIELDS; f++) q.fld[f] = $urandom;
    if (kind < 8) begin
      // degenerate cell on one or both axes
      case ($urandom_range(0, 2))
        0: q.fld[FLD_X_HIGH] = q.fld[FLD_X_LOW];
        1: q.fld[FLD_Y_HIGH] = q.fld[FLD_Y_LOW];
        default: begin
          q.fld[FLD_X_HIGH] = q.fld[FLD_X_LOW];
          q.fld[FLD_Y_HIGH] = q.fld[FLD_Y_LOW];
        end
      endcase
    end else if (kind < 80) begin
      // proper cell, query mostly inside, corners of varied magnitude
      outside = ($urandom_range(0, 99) < 20);
      rand_axis(outside, q.fld[FLD_X_LOW], q.fld[FLD_X_HIGH], q.fld[FLD_QUERY_X]);
      rand_axis(outside, q.fld[FLD_Y_LOW], q.fld[FLD_Y_HIGH], q.fld[FLD_QUERY_Y]);
      if ($urandom_range(0, 9) < 7) begin
        q.fld[FLD_CORNER_A] = rand_span($urandom_range(0, 30));
        q.fld[FLD_CORNER_B] = rand_span($urandom_range(0, 30));
        q.fld[FLD_CORNER_C] = rand_span($urandom_range(0, 30));
        q.fld[FLD_CORNER_D] = rand_span($urandom_range(0, 30));
      end
    end else if (kind >= 88) begin
      for (int f = 0; f < N_IN_FIELDS; f++) q.fld[f] = rand_extreme();
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  task automatic send_query(input query_t q, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv_query = q;
    for (int f = 0; f < N_IN_FIELDS; f++) in_tdata[f*DW +: DW] = q.fld[f];
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_stream();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  task automatic run_random(input int n, input int tx_pct, input int rx_pct);
    int gap;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      gap = ($urandom_range(0, 99) < tx_pct) ? idle_length() : 0;
      send_query(rand_query(), gap);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        out_tready = 1'b0;
        stall_left = idle_length() - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Beat monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_query(drv_query);
      if (in_tvalid && !in_tready) in_stall_cycles++;
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                 $time, WD_LIMIT, sb.outstanding());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    query_t dir_q[$];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // degenerate cells, including all-ones and all-extreme fields
    dir_q.push_back(mk(ONE, 2*ONE, 3*ONE, 4*ONE, 0, 0, 0, ONE, ONE/2, ONE/2));
    dir_q.push_back(mk(-ONE, MAXV, MINV, 7, 0, ONE, 5*ONE, 5*ONE, ONE/2, ONE/2));
    dir_q.push_back(mk(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    dir_q.push_back(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    dir_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    // query on each corner of a unit cell returns that corner exactly
    dir_q.push_back(mk(MINV, MAXV, -ONE, 12345, 0, ONE, 0, ONE, 0, 0));
    dir_q.push_back(mk(MINV, MAXV, -ONE, 12345, 0, ONE, 0, ONE, 0, ONE));
    dir_q.push_back(mk(MINV, MAXV, -ONE, 12345, 0, ONE, 0, ONE, ONE, 0));
    dir_q.push_back(mk(MINV, MAXV, -ONE, 12345, 0, ONE, 0, ONE, ONE, ONE));
    // rounding: quarter drops, positive and negative halves go away from zero
    dir_q.push_back(mk(1, 0, 0, 0, 0, ONE, 0, ONE, ONE/2, ONE/2));
    dir_q.push_back(mk(1, 0, 0, 0, 0, ONE, 0, ONE, ONE/2, 0));
    dir_q.push_back(mk(-1, 0, 0, 0, 0, ONE, 0, ONE, ONE/2, 0));
    dir_q.push_back(mk(-3, 0, 0, 0, 0, 2, 0, 2, 1, 0));
    // reversed grid on both axes, and on x only with zero corners
    dir_q.push_back(mk(ONE, -2*ONE, 3*ONE, 5*ONE, ONE, 0, ONE, 0, ONE/4, 3*ONE/4));
    dir_q.push_back(mk(0, 0, 0, 0, ONE, 0, 0, ONE, ONE/3, ONE/5));
    // far extrapolation into both saturation limits
    dir_q.push_back(mk(MAXV, 0, 0, MINV, 0, 1, 0, 1, MAXV, MAXV));
    dir_q.push_back(mk(MAXV, 0, 0, MINV, 0, 1, 0, 1, MINV, MINV));
    dir_q.push_back(mk(MINV, 0, 0, MAXV, 0, 1, 0, 1, MAXV, MINV));
    dir_q.push_back(mk(ONE, -ONE, 2*ONE, MAXV, 0, ONE, 0, ONE, 2*ONE, 2*ONE));
    dir_q.push_back(mk(MINV, ONE, -ONE, MINV, 0, ONE, 0, ONE, 2*ONE, 2*ONE));
    // widest possible grid, forward and reversed, and a small grid with far queries
    dir_q.push_back(mk(MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV));
    dir_q.push_back(mk(MAXV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV, 0, 0));
    dir_q.push_back(mk(12345, -54321, ONE, -ONE, -ONE, ONE, -ONE, ONE, -3*ONE, 3*ONE));
    rx_idle_pct = 0;
    foreach (dir_q[i]) send_query(dir_q[i], 0);

    // random traffic with idling on both sides
    run_random(400, 25, 25);

    // receiver holds off while the sender keeps pushing, pipeline fills up
    rx_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) send_query(rand_query(), 0);

    // sender pauses until the pipeline has drained
    stop_stream();
    wait_drained();

    // back-to-back beats, then heavy idling
    run_random(400, 0, 0);
    run_random(380, 50, 40);

    stop_stream();
    wait_drained();
    repeat (TAIL) @(posedge clk);

    $display("Covered %0d queries (%0d degenerate cells, %0d saturated results),",
             sb.n_queries, sb.n_zero_area, sb.n_clipped);
    $display("%0d results checked, input held off %0d cycles, %0d mismatches",
             sb.n_results, in_stall_cycles, sb.n_errors);
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bli_pkg.sv
hdl/bli_mac.sv
hdl/bli_div_step.sv
hdl/bli_divider.sv
hdl/bli_round.sv
hdl/bilinear_interpolation_2d_top.sv
dv/tb_bilinear_interpolation_2d_top.sv
